// ===== rtl/c1c2c3_color_convert_unit_macros.svh =====
// Assertion macros for the c1c2c3 color converter.
`ifndef C1C2C3_COLOR_CONVERT_UNIT_MACROS_SVH
`define C1C2C3_COLOR_CONVERT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define C1C2C3_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define C1C2C3_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define C1C2C3_ASSERT(label, prop, msg)
`define C1C2C3_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ===== rtl/c1c2c3_pkg.sv =====
// Package with the item types, constants and angle table of the c1c2c3 color converter.
package c1c2c3_pkg;

	// Default number of fraction bits of the angle arithmetic.
	localparam int ANGLE_FRAC_BITS = 16;

	// One lane per output channel.
	localparam int LANES = 3;

	// Integer bits of the x and y registers, sign included (values stay below 1024).
	localparam int X_INT_BITS = 11;

	// Integer bits of the angle register, sign included.
	localparam int Z_INT_BITS = 3;

	// Largest channel value; also the scale factor of the angle.
	localparam logic [7:0] CHANNEL_MAX = 8'd255;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] c3;
	} result_t;

	// Special-case flags that travel with an item through the cells.
	typedef struct packed {
		logic [LANES-1:0] num_zero;
		logic [LANES-1:0] den_zero;
	} lane_flags_t;

	// atan(2^-shift) rounded to nearest at frac fraction bits, evaluated at elaboration.
	function automatic int angle_step(input int shift, input int frac);
		return $rtoi($atan(2.0 ** (-shift)) * (2.0 ** frac) + 0.5);
	endfunction

endpackage

// ===== rtl/c1c2c3_color_convert_unit.sv =====
// Top level of the c1c2c3 color converter: a chain of rotation cells between front and back end.
//
// Converts blue, green, red pixels into the three color-invariant angle channels
// c1, c2, c3. A pixel passes a front end, a chain of ANGLE_FRAC_BITS + 1 rotation cells (one
// registered arctangent step each, all three channels side by side) and a scaling stage into
// the result register. When nothing stalls, a new pixel is taken in every cycle. When
// result_stall holds a result, pixels keep entering until every cell holds an item;
// pixel_stall rises only then. Each cell advances when its successor is empty or
// advancing, and that ready path runs combinationally through the whole chain.
module c1c2c3_color_convert_unit #(
	parameter int ANGLE_FRAC_BITS = c1c2c3_pkg::ANGLE_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  c1c2c3_pkg::pixel_t     pixel,
	output logic                   result_valid,
	input  logic                   result_stall,
	output c1c2c3_pkg::result_t    result
);
	import c1c2c3_pkg::*;
	`include "c1c2c3_color_convert_unit_macros.svh"

	localparam int CELLS = ANGLE_FRAC_BITS + 1;
	localparam int XW    = ANGLE_FRAC_BITS + X_INT_BITS;
	localparam int ZW    = ANGLE_FRAC_BITS + Z_INT_BITS;

	// Position 0 is the front end, position k + 1 the output of cell k.
	logic [CELLS:0]                     valid_chain;
	logic [CELLS:0]                     load;
	lane_flags_t [CELLS:0]              flags_chain;
	logic [CELLS:0][LANES-1:0][XW-1:0]  x_chain;
	logic [CELLS:0][LANES-1:0][XW-1:0]  y_chain;
	logic [CELLS:0][LANES-1:0][ZW-1:0]  z_chain;

	result_t scaled;
	result_t result_q;
	logic    result_valid_q;

	// Front end feeds the first cell.
	c1c2c3_prep #(
		.FRAC   (ANGLE_FRAC_BITS)
	) u_prep (
		.pixel  (pixel),
		.x_init (x_chain[0]),
		.y_init (y_chain[0]),
		.flags  (flags_chain[0])
	);

	assign valid_chain[0] = pixel_valid;
	assign z_chain[0]     = '0;

	// Chain of rotation cells, cell k shifting by k.
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		c1c2c3_cell #(
			.FRAC     (ANGLE_FRAC_BITS),
			.SHIFT    (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load[k]),
			.valid_in (valid_chain[k]),
			.flags_in (flags_chain[k]),
			.x_in     (x_chain[k]),
			.y_in     (y_chain[k]),
			.z_in     (z_chain[k]),
			.valid_q  (valid_chain[k+1]),
			.flags_q  (flags_chain[k+1]),
			.x_q      (x_chain[k+1]),
			.y_q      (y_chain[k+1]),
			.z_q      (z_chain[k+1])
		);

		// A cell loads when its successor is empty or loads as well.
		assign load[k] = !valid_chain[k+1] || load[k+1];
	end

	// Scaling of the last cell's angles.
	c1c2c3_scale #(
		.FRAC   (ANGLE_FRAC_BITS)
	) u_scale (
		.z      (z_chain[CELLS]),
		.flags  (flags_chain[CELLS]),
		.result (scaled)
	);

	// The result register takes a new item when empty or when its item is taken.
	assign load[CELLS] = !result_valid_q || !result_stall;
	assign pixel_stall = !load[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load[CELLS]) begin
			result_valid_q <= valid_chain[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (load[CELLS]) begin
			result_q <= scaled;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Input stalls only behind a blocked result, and only once every cell holds an item.
	`C1C2C3_ASSERT_NEVER(a_stall_only_when_blocked, pixel_stall && !(result_valid_q && result_stall), "pixel stalled while the result side is free")
	`C1C2C3_ASSERT(a_stall_means_full, pixel_stall |-> (&valid_chain[CELLS:1]), "pixel stalled while a cell is empty")

endmodule

// ===== rtl/c1c2c3_prep.sv =====
// Front end of the c1c2c3 color converter: denominators, special-case flags, start vectors.
module c1c2c3_prep #(
	parameter int FRAC = c1c2c3_pkg::ANGLE_FRAC_BITS,
	localparam int XW = FRAC + c1c2c3_pkg::X_INT_BITS
) (
	input  c1c2c3_pkg::pixel_t                          pixel,
	output logic [c1c2c3_pkg::LANES-1:0][XW-1:0]        x_init,
	output logic [c1c2c3_pkg::LANES-1:0][XW-1:0]        y_init,
	output c1c2c3_pkg::lane_flags_t                     flags
);
	import c1c2c3_pkg::*;

	logic [LANES-1:0][7:0] num;
	logic [LANES-1:0][7:0] den;

	function automatic logic [7:0] larger(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a : b;
	endfunction

	// Each channel divides its own color by the larger of the other two.
	always_comb begin
		num[0] = pixel.red;
		den[0] = larger(pixel.green, pixel.blue);
		num[1] = pixel.green;
		den[1] = larger(pixel.red, pixel.blue);
		num[2] = pixel.blue;
		den[2] = larger(pixel.red, pixel.green);
	end

	// Start vector (den, num) in fixed point, and the zero flags.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			x_init[k] = {{(X_INT_BITS - 8){1'b0}}, den[k], {FRAC{1'b0}}};
			y_init[k] = {{(X_INT_BITS - 8){1'b0}}, num[k], {FRAC{1'b0}}};
			flags.num_zero[k] = (num[k] == 8'd0);
			flags.den_zero[k] = (den[k] == 8'd0);
		end
	end

endmodule

// ===== rtl/c1c2c3_cell.sv =====
// One vectoring rotation cell of the c1c2c3 color converter, three lanes wide, registered.
module c1c2c3_cell #(
	parameter int FRAC  = c1c2c3_pkg::ANGLE_FRAC_BITS,
	parameter int SHIFT = 0,
	localparam int XW = FRAC + c1c2c3_pkg::X_INT_BITS,
	localparam int ZW = FRAC + c1c2c3_pkg::Z_INT_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        load,
	input  logic                                        valid_in,
	input  c1c2c3_pkg::lane_flags_t                     flags_in,
	input  logic [c1c2c3_pkg::LANES-1:0][XW-1:0]        x_in,
	input  logic [c1c2c3_pkg::LANES-1:0][XW-1:0]        y_in,
	input  logic [c1c2c3_pkg::LANES-1:0][ZW-1:0]        z_in,
	output logic                                        valid_q,
	output c1c2c3_pkg::lane_flags_t                     flags_q,
	output logic [c1c2c3_pkg::LANES-1:0][XW-1:0]        x_q,
	output logic [c1c2c3_pkg::LANES-1:0][XW-1:0]        y_q,
	output logic [c1c2c3_pkg::LANES-1:0][ZW-1:0]        z_q
);
	import c1c2c3_pkg::*;

	localparam logic signed [ZW-1:0] STEP = ZW'(angle_step(SHIFT, FRAC));

	logic [LANES-1:0][XW-1:0] x_next;
	logic [LANES-1:0][XW-1:0] y_next;
	logic [LANES-1:0][ZW-1:0] z_next;

	// Rotate toward the x axis by atan(2^-SHIFT); both updates use the old x and y.
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic signed [XW-1:0] x_cur;
		logic signed [XW-1:0] y_cur;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [ZW-1:0] z_cur;
		logic                 y_neg;

		assign x_cur = $signed(x_in[k]);
		assign y_cur = $signed(y_in[k]);
		assign z_cur = $signed(z_in[k]);
		assign dx = y_cur >>> SHIFT;
		assign dy = x_cur >>> SHIFT;
		assign y_neg = y_cur[XW-1];

		assign x_next[k] = y_neg ? (x_cur - dx) : (x_cur + dx);
		assign y_next[k] = y_neg ? (y_cur + dy) : (y_cur - dy);
		assign z_next[k] = y_neg ? (z_cur - STEP) : (z_cur + STEP);
	end

	// Item valid bit of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_in;
		end
	end

	// Lane payload of this cell.
	always_ff @(posedge clk) begin
		if (load) begin
			flags_q <= flags_in;
			x_q     <= x_next;
			y_q     <= y_next;
			z_q     <= z_next;
		end
	end

endmodule

// ===== rtl/c1c2c3_scale.sv =====
// Back end of the c1c2c3 color converter: angle times 255, rounding, saturation, special cases.
module c1c2c3_scale #(
	parameter int FRAC = c1c2c3_pkg::ANGLE_FRAC_BITS,
	localparam int ZW = FRAC + c1c2c3_pkg::Z_INT_BITS
) (
	input  logic [c1c2c3_pkg::LANES-1:0][ZW-1:0]        z,
	input  c1c2c3_pkg::lane_flags_t                     flags,
	output c1c2c3_pkg::result_t                         result
);
	import c1c2c3_pkg::*;

	// Product width: clamped angle magnitude plus eight bits for the factor 255.
	localparam int PW = ZW - 1 + 8;
	localparam int WW = PW - FRAC;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC - 1);

	logic [LANES-1:0][7:0] chan;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic [ZW-2:0] mag;
		logic [PW-1:0] prod;
		logic [WW-1:0] whole;

		// Negative angles clamp to zero; 255*z is z*256 - z.
		assign mag   = z[k][ZW-1] ? '0 : z[k][ZW-2:0];
		assign prod  = {mag, 8'd0} - PW'(mag) + HALF;
		assign whole = prod[PW-1:FRAC];

		// A zero numerator wins over a zero denominator (0/0 gives zero).
		assign chan[k] = flags.num_zero[k] ? 8'd0 :
			(flags.den_zero[k] || (whole > WW'(CHANNEL_MAX))) ? CHANNEL_MAX : whole[7:0];
	end

	assign result = '{c1: chan[0], c2: chan[1], c3: chan[2]};

endmodule
